[sv/vmt_pkg.sv]
// Package for the vertex matrix transform unit: sizes, item types, the
// back-end state type and the fixed-point helper functions.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package vmt_pkg;

    localparam int NUM_PAIRS     = 8;
    localparam int CFG_IDX_W     = 4;
    localparam int QDEPTH        = 8;
    localparam int QAW           = 3;
    localparam int NEAR_ZERO_Q16 = 66;
    localparam int DIV_STEPS     = 65;

    typedef logic signed [65:0] t_sum;
    typedef logic [NUM_PAIRS-1:0][63:0] t_matrix;

    // One classified transaction on its way from the front to the back.
    typedef struct packed {
        t_sum        sx;
        t_sum        sy;
        t_sum        sz;
        logic [47:0] dv;
        logic        dneg;
        logic        div;
    } t_item;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } t_back_state;

    function automatic logic signed [63:0] clamp64(t_sum s);
        logic signed [63:0] res;
        if (s[65:63] == 3'b000 || s[65:63] == 3'b111) begin
            res = s[63:0];
        end else if (s[65]) begin
            res = {1'b1, 63'b0};
        end else begin
            res = {1'b0, {63{1'b1}}};
        end
        return res;
    endfunction

    // Q32.32 to Q16.16, nearest, ties toward plus infinity; one guard bit.
    function automatic logic signed [48:0] round_q16(logic signed [63:0] c);
        logic [48:0] res;
        res = {c[63], c[63:16]} + {48'b0, c[15]};
        return res;
    endfunction

endpackage

[sv/vmt_front.sv]
// Front end of the vertex matrix transform: products, column sums and
// classification of the fourth component. Depends on vmt_pkg.
`timescale 1ns / 1ps

module vmt_front import vmt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_mode,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    input  logic signed [31:0] i_w,
    input  t_matrix            i_mat,
    output logic               o_push,
    output t_item              o_item,
    output logic [1:0]         o_inflight
);

    logic signed [31:0] v [4];
    logic signed [63:0] r_p [4][4];
    t_sum               r_s [4];
    logic               r_v1, r_v2, r_v3;
    logic               r_mode1, r_mode2;
    t_item              r_item;
    logic signed [48:0] w;
    logic [48:0]        mag;

    assign v[0] = i_x;
    assign v[1] = i_y;
    assign v[2] = i_z;
    assign v[3] = i_w;

    for (genvar gr = 0; gr < 4; gr++) begin : g_row
        for (genvar gc = 0; gc < 4; gc++) begin : g_col
            logic [63:0]        pair;
            logic signed [31:0] cf;
            assign pair = i_mat[2*gr + gc/2];
            assign cf   = (gc % 2 == 1) ? pair[63:32] : pair[31:0];
            always_ff @(posedge i_clk) begin
                if (i_accept) begin
                    r_p[gc][gr] <= v[gr] * cf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_s[c] <= 66'(r_p[c][0]) + 66'(r_p[c][1]) + 66'(r_p[c][2]) + 66'(r_p[c][3]);
        end
        if (i_accept) begin
            r_mode1 <= i_mode;
        end
        r_mode2 <= r_mode1;
    end

    always_comb begin
        w   = round_q16(clamp64(r_s[3]));
        mag = w[48] ? (49'd0 - w) : w;
    end

    always_ff @(posedge i_clk) begin
        r_item.sx   <= r_s[0];
        r_item.sy   <= r_s[1];
        r_item.sz   <= r_s[2];
        r_item.dv   <= mag[47:0];
        r_item.dneg <= w[48];
        r_item.div  <= r_mode2 && (mag > 49'(NEAR_ZERO_Q16));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_push     = r_v3;
    assign o_item     = r_item;
    assign o_inflight = 2'(r_v1) + 2'(r_v2) + 2'(r_v3);

endmodule

[sv/vmt_fifo.sv]
// Short queue between the front and back of the transform unit.
// Depends on vmt_pkg for the item type and depth.
`timescale 1ns / 1ps

module vmt_fifo import vmt_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_item          i_item,
    input  logic           i_pop,
    output t_item          o_item,
    output logic           o_empty,
    output logic [QAW:0]   o_count
);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_cnt == (QAW+1)'(QDEPTH)))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_cnt == '0))
        else $error("queue read while empty");

endmodule

[sv/vmt_back.sv]
// Back end of the transform unit: rounding and saturation, and a
// restoring divider with three lanes for the perspective divide. Depends on vmt_pkg.
`timescale 1ns / 1ps

module vmt_back import vmt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    output logic        o_divided,
    output logic        o_saturated
);

    t_back_state r_state, n_state;
    logic [6:0]  r_cnt;
    logic [64:0] r_mag [3];
    logic [47:0] r_rem [3];
    logic [64:0] r_q   [3];
    logic        r_neg [3];
    logic [47:0] r_dv;
    logic        r_dneg;
    logic        r_valid;
    logic [31:0] r_out [3];
    logic        r_divided, r_saturated;

    logic        load;
    logic        last;
    t_sum        s_in  [3];
    logic [31:0] nd_val [3];
    logic        nd_sat [3];
    logic [47:0] n_rem [3];
    logic [64:0] n_q   [3];
    logic [31:0] dv_val [3];
    logic        dv_sat [3];

    assign s_in[0] = i_item.sx;
    assign s_in[1] = i_item.sy;
    assign s_in[2] = i_item.sz;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (!i_empty && i_item.div) n_state = BK_DIV;
            BK_DIV:  if (r_cnt == '0) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        last  = 1'b0;
        unique case (r_state)
            BK_IDLE: o_pop = !i_empty;
            BK_DIV:  last  = (r_cnt == '0);
            default: o_pop = 1'b0;
        endcase
    end

    assign load = o_pop && i_item.div;

    always_comb begin
        logic signed [48:0] rv;
        logic [48:0]        rs;
        logic               ge;
        logic [48:0]        tmp;
        logic               rnd;
        logic [65:0]        qr;
        for (int l = 0; l < 3; l++) begin
            rv = round_q16(clamp64(s_in[l]));
            nd_sat[l] = 1'b0;
            nd_val[l] = rv[31:0];
            if (rv > 49'sh0_7FFF_FFFF) begin
                nd_sat[l] = 1'b1;
                nd_val[l] = 32'h7FFF_FFFF;
            end else if (rv < -49'sh0_8000_0000) begin
                nd_sat[l] = 1'b1;
                nd_val[l] = 32'h8000_0000;
            end

            rs       = {r_rem[l], r_mag[l][64]};
            ge       = rs >= {1'b0, r_dv};
            tmp      = rs - {1'b0, r_dv};
            n_rem[l] = ge ? tmp[47:0] : rs[47:0];
            n_q[l]   = {r_q[l][63:0], ge};

            // Round to nearest on the magnitude, ties away from zero.
            rnd = n_rem[l] >= (r_dv - n_rem[l]);
            qr  = {1'b0, n_q[l]} + 66'(rnd);
            dv_sat[l] = 1'b0;
            if (r_neg[l] != r_dneg) begin
                if (qr > 66'h0_8000_0000) begin
                    dv_sat[l] = 1'b1;
                    dv_val[l] = 32'h8000_0000;
                end else begin
                    dv_val[l] = 32'd0 - qr[31:0];
                end
            end else begin
                if (qr > 66'h0_7FFF_FFFF) begin
                    dv_sat[l] = 1'b1;
                    dv_val[l] = 32'h7FFF_FFFF;
                end else begin
                    dv_val[l] = qr[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dv   <= i_item.dv;
            r_dneg <= i_item.dneg;
            r_cnt  <= 7'(DIV_STEPS - 1);
            for (int l = 0; l < 3; l++) begin
                logic [65:0] m;
                m = s_in[l][65] ? (66'd0 - s_in[l]) : s_in[l];
                r_neg[l] <= s_in[l][65];
                r_mag[l] <= m[64:0];
                r_rem[l] <= '0;
                r_q[l]   <= '0;
            end
        end else if (r_state == BK_DIV) begin
            r_cnt <= r_cnt - 1'b1;
            for (int l = 0; l < 3; l++) begin
                r_mag[l] <= {r_mag[l][63:0], 1'b0};
                r_rem[l] <= n_rem[l];
                r_q[l]   <= n_q[l];
            end
        end

        if (o_pop && !i_item.div) begin
            for (int l = 0; l < 3; l++) r_out[l] <= nd_val[l];
            r_divided   <= 1'b0;
            r_saturated <= nd_sat[0] | nd_sat[1] | nd_sat[2];
        end else if (last) begin
            for (int l = 0; l < 3; l++) r_out[l] <= dv_val[l];
            r_divided   <= 1'b1;
            r_saturated <= dv_sat[0] | dv_sat[1] | dv_sat[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (o_pop && !i_item.div) || last;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_divided   = r_divided;
    assign o_saturated = r_saturated;

    a_div_from_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divided |-> $past(r_state == BK_DIV))
        else $error("divided result without a divider pass");

endmodule

[sv/vertex_matrix_transform_unit.sv]
// Top level of the vertex matrix transform unit: matrix registers, front end,
// queue and back end. Depends on vmt_pkg, vmt_front, vmt_fifo and vmt_back.
`timescale 1ns / 1ps

// A point is taken when start is high and busy is low; one result follows per
// point, in order, as a one-cycle o_valid strobe, and the receiver cannot stall.
// Points with no perspective divide (mode 0, or a fourth component too near zero)
// stream at one per cycle while no divided point ahead of them holds the back end. A
// divided point holds the shared three-lane restoring divider, one quotient bit
// per cycle, after a load step; while it runs, later points wait in the
// eight-entry queue and busy rises once the queue and the three front stages
// together hold eight transactions.

module vertex_matrix_transform_unit import vmt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_mode,
    input  logic signed [31:0]   i_in_x,
    input  logic signed [31:0]   i_in_y,
    input  logic signed [31:0]   i_in_z,
    input  logic signed [31:0]   i_in_w,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    output logic                 o_valid,
    output logic signed [31:0]   o_out_x,
    output logic signed [31:0]   o_out_y,
    output logic signed [31:0]   o_out_z,
    output logic                 o_divided,
    output logic                 o_saturated
);

    t_matrix      r_mat;
    logic         accept;
    logic         push, pop, empty;
    t_item        f_item, q_item;
    logic [1:0]   inflight;
    logic [QAW:0] count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= 64'h0000_0000_0001_0000;
            r_mat[1] <= 64'h0000_0000_0000_0000;
            r_mat[2] <= 64'h0001_0000_0000_0000;
            r_mat[3] <= 64'h0000_0000_0000_0000;
            r_mat[4] <= 64'h0000_0000_0000_0000;
            r_mat[5] <= 64'h0000_0000_0001_0000;
            r_mat[6] <= 64'h0000_0000_0000_0000;
            r_mat[7] <= 64'h0001_0000_0000_0000;
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(NUM_PAIRS)) begin
            r_mat[i_cfg_idx[2:0]] <= i_cfg_data;
        end
    end

    assign busy   = ({1'b0, count} + (QAW+2)'(inflight)) >= (QAW+2)'(QDEPTH);
    assign accept = start && !busy;

    vmt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_mode     (i_mode),
        .i_x        (i_in_x),
        .i_y        (i_in_y),
        .i_z        (i_in_z),
        .i_w        (i_in_w),
        .i_mat      (r_mat),
        .o_push     (push),
        .o_item     (f_item),
        .o_inflight (inflight)
    );

    vmt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (empty),
        .o_count (count)
    );

    vmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_item),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_divided   (o_divided),
        .o_saturated (o_saturated)
    );

endmodule

[dv/vertex_matrix_transform_unit_tb.sv]
// Self-checking testbench for the vertex matrix transform unit: random and directed points
// across several matrix settings, checked against an in-bench Q16.16 transform predictor.
// Depends on vmt_pkg and the vertex_matrix_transform_unit RTL.
`timescale 1ns / 1ps

module vertex_matrix_transform_unit_tb;
    import vmt_pkg::*;

    localparam logic MODE_AFFINE = 1'b0;
    localparam logic MODE_PERSP  = 1'b1;
    localparam int   ITEMS_PER_PHASE = 180;
    localparam int   NUM_PHASES      = 9;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef struct {
        logic              mode;
        logic signed [31:0] x, y, z, w;
    } t_vertex;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               divided;
        logic               saturated;
    } t_xform;

    logic i_clk, i_rst_n;
    logic start, busy;
    logic i_mode;
    logic signed [31:0] i_in_x, i_in_y, i_in_z, i_in_w;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic o_valid;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic o_divided, o_saturated;

    vertex_matrix_transform_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_in_x(i_in_x), .i_in_y(i_in_y), .i_in_z(i_in_z),
        .i_in_w(i_in_w), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_out_x(o_out_x),
        .o_out_y(o_out_y), .o_out_z(o_out_z), .o_divided(o_divided),
        .o_saturated(o_saturated)
    );

    logic [63:0] matrix_pairs [NUM_PAIRS];
    t_vertex     pending_vertices[$];
    t_xform      expected_xforms[$];
    int          error_count;
    int          burst_left, gap_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [127:0] clamp_q32(logic signed [127:0] s);
        logic signed [127:0] hi_lim, lo_lim;
        hi_lim = 128'sh7FFF_FFFF_FFFF_FFFF;
        lo_lim = -128'sh8000_0000_0000_0000;
        if (s > hi_lim) return hi_lim;
        if (s < lo_lim) return lo_lim;
        return s;
    endfunction

    // Nearest rounding with ties toward plus infinity is floor((v + half) / 2^16).
    function automatic logic signed [127:0] round_to_q16(logic signed [127:0] v);
        return (v + 128'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] sat_q16(logic signed [127:0] v, ref logic sat);
        if (v > 128'sh7FFF_FFFF) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < -128'sh8000_0000) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] divide_q16(logic signed [127:0] a,
                                                      logic signed [127:0] d, ref logic sat);
        logic [127:0] mag, dv, q, rem;
        mag = a < 0 ? -a : a;
        dv  = d < 0 ? -d : d;
        q   = mag / dv;
        rem = mag % dv;
        if (rem >= dv - rem) q = q + 1;
        if ((a < 0) != (d < 0)) begin
            if (q > 128'h8000_0000) begin
                sat = 1'b1;
                q = 128'h8000_0000;
            end
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            q = 128'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic t_xform transform_vertex(t_vertex vx);
        logic signed [127:0] comp [4];
        logic signed [127:0] sums [4];
        logic signed [127:0] coef, wq, wmag;
        logic [63:0] pair;
        logic sat, div;
        logic signed [31:0] res [3];
        t_xform r;
        comp[0] = vx.x;
        comp[1] = vx.y;
        comp[2] = vx.z;
        comp[3] = vx.w;
        for (int c = 0; c < 4; c++) begin
            sums[c] = 0;
            for (int k = 0; k < 4; k++) begin
                pair = matrix_pairs[(k << 1) | (c >> 1)];
                coef = (c & 1) ? $signed(pair[63:32]) : $signed(pair[31:0]);
                sums[c] = sums[c] + comp[k] * coef;
            end
        end
        sat = 1'b0;
        div = 1'b0;
        wq  = 0;
        if (vx.mode == MODE_PERSP) begin
            wq   = round_to_q16(clamp_q32(sums[3]));
            wmag = wq < 0 ? -wq : wq;
            div  = wmag > NEAR_ZERO_Q16;
        end
        for (int c = 0; c < 3; c++) begin
            if (div) res[c] = divide_q16(sums[c], wq, sat);
            else     res[c] = sat_q16(round_to_q16(clamp_q32(sums[c])), sat);
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        r.divided = div;
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_component(bit near_zero);
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 4))
                   0: return Q_MAX;
                   1: return Q_MIN;
                   2: return 0;
                   3: return -1;
                   default: return Q_ONE;
               endcase
            1, 2: return $urandom;
            3: return near_zero ? $signed($urandom_range(0, 160)) - 80 : $urandom;
            default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            2: return 0;
            default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
    endfunction

    task automatic write_pair(int idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[CFG_IDX_W-1:0];
        i_cfg_data <= data;
        if (idx < NUM_PAIRS) matrix_pairs[idx] = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_vertex(logic mode, logic signed [31:0] x, y, z, w);
        t_vertex vx;
        vx.mode = mode;
        vx.x = x;
        vx.y = y;
        vx.z = z;
        vx.w = w;
        pending_vertices.push_back(vx);
    endtask

    task automatic wait_drained();
        while (pending_vertices.size() != 0 || expected_xforms.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Driver: offers pending vertices in bursts separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else if (pending_vertices.size() != 0) begin
            start  <= 1'b1;
            i_mode <= pending_vertices[0].mode;
            i_in_x <= pending_vertices[0].x;
            i_in_y <= pending_vertices[0].y;
            i_in_z <= pending_vertices[0].z;
            i_in_w <= pending_vertices[0].w;
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // A transaction is taken here, and its prediction is queued at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy && pending_vertices.size() != 0)
            expected_xforms.push_back(transform_vertex(pending_vertices.pop_front()));
    end

    always @(posedge i_clk) begin
        t_xform e;
        if (i_rst_n && o_valid) begin
            if (expected_xforms.size() == 0) begin
                $error("result with no transaction outstanding");
                error_count++;
            end else begin
                e = expected_xforms.pop_front();
                if (o_out_x !== e.x) begin
                    $error("out_x expected %0d actual %0d", e.x, o_out_x);
                    error_count++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y expected %0d actual %0d", e.y, o_out_y);
                    error_count++;
                end
                if (o_out_z !== e.z) begin
                    $error("out_z expected %0d actual %0d", e.z, o_out_z);
                    error_count++;
                end
                if (o_divided !== e.divided) begin
                    $error("divided expected %0d actual %0d", e.divided, o_divided);
                    error_count++;
                end
                if (o_saturated !== e.saturated) begin
                    $error("saturated expected %0d actual %0d", e.saturated, o_saturated);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [31:0] ca, cb;
        error_count = 0;
        burst_left  = 0;
        gap_left    = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_mode      = MODE_AFFINE;
        i_in_x      = 0;
        i_in_y      = 0;
        i_in_z      = 0;
        i_in_w      = 0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        matrix_pairs[0] = 64'd65536;
        matrix_pairs[1] = 64'd0;
        matrix_pairs[2] = 64'd65536 << 32;
        matrix_pairs[3] = 64'd0;
        matrix_pairs[4] = 64'd0;
        matrix_pairs[5] = 64'd65536;
        matrix_pairs[6] = 64'd0;
        matrix_pairs[7] = 64'd65536 << 32;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points under the reset identity matrix; w passes straight to w'.
        push_vertex(MODE_AFFINE, 0, 0, 0, 0);
        push_vertex(MODE_AFFINE, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_vertex(MODE_AFFINE, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_vertex(MODE_AFFINE, Q_MAX, Q_MIN, -1, Q_ONE);
        push_vertex(MODE_PERSP, Q_ONE, -Q_ONE, 3 * Q_ONE, Q_ONE);
        push_vertex(MODE_PERSP, Q_ONE, 2 * Q_ONE, 5, 32'sd66);
        push_vertex(MODE_PERSP, Q_ONE, 2 * Q_ONE, 5, 32'sd67);
        push_vertex(MODE_PERSP, Q_ONE, 2 * Q_ONE, 5, -32'sd66);
        push_vertex(MODE_PERSP, Q_ONE, 2 * Q_ONE, 5, -32'sd67);
        push_vertex(MODE_PERSP, Q_MAX, Q_MIN, 7, 0);
        push_vertex(MODE_PERSP, Q_MAX, Q_MIN, Q_ONE, 32'sd67);
        push_vertex(MODE_PERSP, Q_MAX, Q_MIN, Q_ONE, -32'sd67);
        push_vertex(MODE_PERSP, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_vertex(MODE_PERSP, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_vertex(MODE_PERSP, 32'sd3, -32'sd3, 32'sd1, 2 * Q_ONE);
        push_vertex(MODE_PERSP, -Q_ONE, 0, Q_ONE, -2 * Q_ONE);
        wait_drained();

        for (int phase = 1; phase <= NUM_PHASES; phase++) begin
            for (int k = 0; k < NUM_PAIRS; k++) begin
                case (phase)
                    1: begin
                        ca = (k == 0 || k == 5) ? Q_ONE : 0;
                        cb = (k == 2 || k == 7) ? Q_ONE : 0;
                    end
                    6: begin
                        ca = 32'hFFFF_FFFF;
                        cb = 32'hFFFF_FFFF;
                    end
                    7: begin
                        ca = Q_MIN;
                        cb = Q_MIN;
                    end
                    8: begin
                        ca = Q_MAX;
                        cb = Q_MAX;
                    end
                    default: begin
                        ca = rand_coef();
                        cb = rand_coef();
                    end
                endcase
                write_pair(k, {cb, ca});
            end
            // Writes to indexes past the last pair must leave the matrix alone.
            if (phase == 1 || phase == 4)
                write_pair($urandom_range(NUM_PAIRS, (1 << CFG_IDX_W) - 1), {$urandom, $urandom});
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_vertex($urandom_range(0, 1), rand_component(0), rand_component(0),
                            rand_component(0), rand_component(1));
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/vmt_pkg.sv
sv/vmt_front.sv
sv/vmt_fifo.sv
sv/vmt_back.sv
sv/vertex_matrix_transform_unit.sv
dv/vertex_matrix_transform_unit_tb.sv
